@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Plain property, checked at every rising clock edge outside reset.
`define TAPMM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("tapmm assertion failed");

// Same-cycle implication.
`define TAPMM_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tapmm implication failed");

// Next-cycle implication.
`define TAPMM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tapmm next-cycle check failed");

`else

`define TAPMM_ASSERT(lbl, clk, rst, prop)
`define TAPMM_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define TAPMM_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ rtl/tapmm_pkg.sv @@
// Types, constants and helpers for the three-axis PID motor mixer.
package tapmm_pkg;

  // Request codes
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_ARM    = 2'd1;
  localparam logic [1:0] REQ_DISARM = 2'd2;

  // Config register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_PITCH_KP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_KP         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd4;
  localparam int CFG_DATA_W = 24;

  // Config reset values
  localparam logic [23:0] RST_ROLL_PITCH_KP  = 24'd271974;
  localparam logic [23:0] RST_YAW_KP         = 24'd294912;
  localparam logic [23:0] RST_KI_GAIN        = 24'd524;
  localparam logic [23:0] RST_KD_GAIN        = 24'd72090;
  localparam logic [15:0] RST_INTEGRAL_LIMIT = 16'd6400;

  // Channel thresholds, microseconds
  localparam logic [11:0] THR_LOW  = 12'd1100;
  localparam logic [11:0] WIN_LOW  = 12'd900;
  localparam logic [11:0] WIN_HIGH = 12'd1900;
  localparam logic [11:0] WIN_TOP  = 12'd2100;

  localparam logic [10:0] MOTOR_MIN = 11'd1000;
  localparam logic [10:0] MOTOR_MAX = 11'd2000;

  // Yaw stick scaling: stick/12 via reciprocal multiply (exact for 16-bit magnitudes)
  localparam int YAW_DIV      = 12;
  localparam int YAW_RECIP_SH = 19;
  localparam int YAW_RECIP    = ((1 << YAW_RECIP_SH) + YAW_DIV - 1) / YAW_DIV;
  localparam int YQ_W         = 13;
  localparam logic signed [15:0] YAW_DEADBAND = 16'sd5;

  // Mixer sum width
  localparam int SUM_W = 36;
  localparam int INT_W = 18;
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(256000);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(512000);

  typedef struct packed {
    logic [1:0]             req_type;
    logic signed [16:0]     roll_angle;
    logic signed [16:0]     pitch_angle;
    logic signed [16:0]     yaw_angle;
    logic signed [16:0]     roll_target;
    logic signed [16:0]     pitch_target;
    logic signed [YQ_W-1:0] yaw_quot;
    logic signed [15:0]     yaw_dz;
    logic [11:0]            throttle_channel;
    logic [11:0]            yaw_channel;
  } item_t;

  typedef struct packed {
    logic [23:0] roll_pitch_kp;
    logic [23:0] yaw_kp;
    logic [23:0] ki_gain;
    logic [23:0] kd_gain;
    logic [15:0] integral_limit;
  } cfg_t;

  typedef struct packed {
    logic [3:0][10:0]        motors;
    logic                    armed;
    logic                    accepted;
    logic signed [INT_W-1:0] roll_int;
    logic signed [INT_W-1:0] pitch_int;
  } mix_t;

  function automatic logic [10:0] motor_sat(input logic signed [SUM_W-1:0] s);
    logic [10:0] m;
    priority if (s < SAT_LO) m = MOTOR_MIN;
    else if (s >= SAT_HI)    m = MOTOR_MAX;
    else                     m = s[18:8];
    return m;
  endfunction

  function automatic logic signed [INT_W-1:0] int_clamp(input logic signed [SUM_W-1:0] v,
                                                         input logic [15:0] lim);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] c;
    hi = $signed(SUM_W'(lim));
    priority if (v > hi) c = hi;
    else if (v < -hi)    c = -hi;
    else                 c = v;
    return INT_W'(c);
  endfunction

endpackage

@@ rtl/three_axis_pid_motor_mixer_core.sv @@
// Top level of the three-axis PID attitude controller and quad-X motor mixer.
//
// Usage:
//   Input channel (in_valid / in_stall): one item per handshake, either a
//   control tick, an arm check or a disarm check. Output channel
//   (out_valid / out_stall): exactly one result item per input item, in order.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes the
//   five gain and limit registers; cfg_ready is always high. Write only while
//   the block holds no item. Unknown indexes are ignored.
// Timing: an accepted item waits in the input register until the output slot
//   is free, then moves into the output register and raises out_valid. One
//   item per cycle is sustained while out_stall stays low: the input register
//   feeds the whole PID and mix path, which lands in the output register (that
//   also holds the motor state). Throughput is set by the integrator and
//   armed-flag feedback, closed within that single stage.
// Reset (rst, synchronous): gains return to defaults, integrators clear,
//   the block is disarmed and all motor fields read 1000.
// Stall: when out_stall holds a pending result, one more item is taken
//   into the input register; then in_stall rises until the result is taken.
`include "assert_macros.svh"

module three_axis_pid_motor_mixer_core (
  input  logic                                   clk,
  input  logic                                   rst,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             req_type,
  input  logic signed [16:0]                     roll_angle,
  input  logic signed [16:0]                     pitch_angle,
  input  logic signed [16:0]                     yaw_angle,
  input  logic signed [16:0]                     roll_target,
  input  logic signed [16:0]                     pitch_target,
  input  logic signed [15:0]                     yaw_stick,
  input  logic [11:0]                            throttle_channel,
  input  logic [11:0]                            yaw_channel,
  // output channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [10:0]                            motor_front_a,
  output logic [10:0]                            motor_front_b,
  output logic [10:0]                            motor_rear_a,
  output logic [10:0]                            motor_rear_b,
  output logic                                   armed_now,
  output logic                                   request_accepted,
  // config channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tapmm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tapmm_pkg::CFG_DATA_W-1:0]       cfg_data
);

  tapmm_pkg::cfg_t  cfg;
  tapmm_pkg::item_t item;
  tapmm_pkg::mix_t  mix;

  logic in_full;
  logic adv;            // input register moves into the output register
  logic in_take;
  logic [3:0][10:0] motors;
  logic signed [tapmm_pkg::INT_W-1:0] roll_int, pitch_int;

  assign cfg_ready = 1'b1;

  // Output slot frees when empty or being taken this cycle
  assign adv      = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !(!out_valid || !out_stall);
  assign in_take  = in_valid && !in_stall;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.roll_pitch_kp  <= tapmm_pkg::RST_ROLL_PITCH_KP;
      cfg.yaw_kp         <= tapmm_pkg::RST_YAW_KP;
      cfg.ki_gain        <= tapmm_pkg::RST_KI_GAIN;
      cfg.kd_gain        <= tapmm_pkg::RST_KD_GAIN;
      cfg.integral_limit <= tapmm_pkg::RST_INTEGRAL_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tapmm_pkg::CFG_ROLL_PITCH_KP:  cfg.roll_pitch_kp  <= cfg_data;
        tapmm_pkg::CFG_YAW_KP:         cfg.yaw_kp         <= cfg_data;
        tapmm_pkg::CFG_KI_GAIN:        cfg.ki_gain        <= cfg_data;
        tapmm_pkg::CFG_KD_GAIN:        cfg.kd_gain        <= cfg_data;
        tapmm_pkg::CFG_INTEGRAL_LIMIT: cfg.integral_limit <= cfg_data[15:0];
        default: begin
          // write beyond the register list is dropped
        end
      endcase
    end
  end

  tapmm_in_stage u_in (
    .clk              (clk),
    .load             (in_take),
    .req_type         (req_type),
    .roll_angle       (roll_angle),
    .pitch_angle      (pitch_angle),
    .yaw_angle        (yaw_angle),
    .roll_target      (roll_target),
    .pitch_target     (pitch_target),
    .yaw_stick        (yaw_stick),
    .throttle_channel (throttle_channel),
    .yaw_channel      (yaw_channel),
    .item             (item)
  );

  tapmm_mixer u_mix (
    .item      (item),
    .cfg       (cfg),
    .roll_int  (roll_int),
    .pitch_int (pitch_int),
    .armed     (armed_now),
    .motors    (motors),
    .mix       (mix)
  );

  // Handshake control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        in_full <= 1'b1;
      end else if (adv) begin
        in_full <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Controller state; the motor and armed outputs double as state
  always_ff @(posedge clk) begin
    if (rst) begin
      roll_int         <= '0;
      pitch_int        <= '0;
      armed_now        <= 1'b0;
      motors           <= {4{tapmm_pkg::MOTOR_MIN}};
      request_accepted <= 1'b0;
    end else if (adv) begin
      roll_int         <= mix.roll_int;
      pitch_int        <= mix.pitch_int;
      armed_now        <= mix.armed;
      motors           <= mix.motors;
      request_accepted <= mix.accepted;
    end
  end

  assign motor_front_a = motors[0];
  assign motor_front_b = motors[1];
  assign motor_rear_a  = motors[2];
  assign motor_rear_b  = motors[3];

  `TAPMM_ASSERT(a_motor_range, clk, rst,
                motor_front_a >= tapmm_pkg::MOTOR_MIN && motor_front_a <= tapmm_pkg::MOTOR_MAX
                && motor_rear_b >= tapmm_pkg::MOTOR_MIN && motor_rear_b <= tapmm_pkg::MOTOR_MAX)
  `TAPMM_ASSERT_NEXT(a_item_held, clk, rst, in_full && !adv, in_full)
  `TAPMM_ASSERT_NEXT(a_state_quiet, clk, rst, !adv, $stable({armed_now, roll_int, motors}))

endmodule

@@ rtl/tapmm_in_stage.sv @@
// Input register: captures an item, pre-scales the yaw stick and applies its deadband.
module tapmm_in_stage (
  input  logic                 clk,
  input  logic                 load,
  input  logic [1:0]           req_type,
  input  logic signed [16:0]   roll_angle,
  input  logic signed [16:0]   pitch_angle,
  input  logic signed [16:0]   yaw_angle,
  input  logic signed [16:0]   roll_target,
  input  logic signed [16:0]   pitch_target,
  input  logic signed [15:0]   yaw_stick,
  input  logic [11:0]          throttle_channel,
  input  logic [11:0]          yaw_channel,
  output tapmm_pkg::item_t     item
);

  logic [15:0] mag;
  logic [31:0] prod;
  logic [tapmm_pkg::YQ_W-2:0] qmag;
  logic signed [tapmm_pkg::YQ_W-1:0] quot;
  logic signed [15:0] dz;
  tapmm_pkg::item_t item_next;

  // |stick| / 12, truncated, then sign restored (C-style division)
  assign mag  = yaw_stick[15] ? 16'(-(17'(yaw_stick))) : 16'(yaw_stick);
  assign prod = 32'(mag) * 32'(tapmm_pkg::YAW_RECIP);
  assign qmag = prod[tapmm_pkg::YAW_RECIP_SH +: (tapmm_pkg::YQ_W-1)];
  assign quot = yaw_stick[15] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

  assign dz = (yaw_stick >= -tapmm_pkg::YAW_DEADBAND && yaw_stick <= tapmm_pkg::YAW_DEADBAND)
              ? 16'sd0 : yaw_stick;

  always_comb begin
    item_next.req_type         = req_type;
    item_next.roll_angle       = roll_angle;
    item_next.pitch_angle      = pitch_angle;
    item_next.yaw_angle        = yaw_angle;
    item_next.roll_target      = roll_target;
    item_next.pitch_target     = pitch_target;
    item_next.yaw_quot         = quot;
    item_next.yaw_dz           = dz;
    item_next.throttle_channel = throttle_channel;
    item_next.yaw_channel      = yaw_channel;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_next;
    end
  end

endmodule

@@ rtl/tapmm_mixer.sv @@
// PID terms, integrator update, quad-X mix and arm/disarm decode.
module tapmm_mixer (
  input  tapmm_pkg::item_t                      item,
  input  tapmm_pkg::cfg_t                       cfg,
  input  logic signed [tapmm_pkg::INT_W-1:0]    roll_int,
  input  logic signed [tapmm_pkg::INT_W-1:0]    pitch_int,
  input  logic                                  armed,
  input  logic [3:0][10:0]                      motors,
  output tapmm_pkg::mix_t                       mix
);

  localparam int SW = tapmm_pkg::SUM_W;

  logic signed [17:0] rerr, perr;
  logic signed [20:0] yerr;
  logic signed [16:0] nstick;
  logic signed [24:0] kp_s, ykp_s, ki_s, kd_s;
  logic signed [42:0] rp_prod, pp_prod, ri_prod, pi_prod;
  logic signed [45:0] yp_prod;
  logic signed [41:0] yd_prod;
  logic signed [SW-1:0] rp, pp, yp, yd, ri_sum, pi_sum;
  logic signed [tapmm_pkg::INT_W-1:0] ri_new, pi_new;
  logic signed [SW-1:0] r, p, y, base;
  logic thr_low, thr_win, arm_win, disarm_win;
  logic [3:0][10:0] mixed;

  assign rerr   = 18'(item.roll_angle) - 18'(item.roll_target);
  assign perr   = 18'(item.pitch_angle) - 18'(item.pitch_target);
  assign yerr   = 21'(item.yaw_angle) - $signed({item.yaw_quot, 8'b0});
  assign nstick = -(17'(item.yaw_dz));

  assign kp_s  = $signed({1'b0, cfg.roll_pitch_kp});
  assign ykp_s = $signed({1'b0, cfg.yaw_kp});
  assign ki_s  = $signed({1'b0, cfg.ki_gain});
  assign kd_s  = $signed({1'b0, cfg.kd_gain});

  assign rp_prod = kp_s * rerr;
  assign pp_prod = kp_s * perr;
  assign ri_prod = ki_s * rerr;
  assign pi_prod = ki_s * perr;
  assign yp_prod = ykp_s * yerr;
  assign yd_prod = kd_s * nstick;

  // arithmetic shifts give floor rounding
  assign rp = SW'(rp_prod >>> 16);
  assign pp = SW'(pp_prod >>> 16);
  assign yp = SW'(yp_prod >>> 16);
  assign yd = SW'(yd_prod >>> 8);

  assign thr_low = item.throttle_channel < tapmm_pkg::THR_LOW;

  assign ri_sum = SW'(roll_int) + SW'(ri_prod >>> 16);
  assign pi_sum = SW'(pitch_int) + SW'(pi_prod >>> 16);
  assign ri_new = thr_low ? '0 : tapmm_pkg::int_clamp(ri_sum, cfg.integral_limit);
  assign pi_new = thr_low ? '0 : tapmm_pkg::int_clamp(pi_sum, cfg.integral_limit);

  assign r    = rp + SW'(ri_new);
  assign p    = pp + SW'(pi_new);
  assign y    = yp + yd;
  assign base = $signed(SW'({item.throttle_channel, 8'b0}));

  assign mixed[0] = tapmm_pkg::motor_sat(base + r - p + y);
  assign mixed[1] = tapmm_pkg::motor_sat(base - r - p - y);
  assign mixed[2] = tapmm_pkg::motor_sat(base - r + p + y);
  assign mixed[3] = tapmm_pkg::motor_sat(base + r + p - y);

  assign thr_win    = item.throttle_channel > tapmm_pkg::WIN_LOW && thr_low;
  assign arm_win    = thr_win && item.yaw_channel > tapmm_pkg::WIN_HIGH
                      && item.yaw_channel < tapmm_pkg::WIN_TOP;
  assign disarm_win = thr_win && item.yaw_channel > tapmm_pkg::WIN_LOW
                      && item.yaw_channel < tapmm_pkg::THR_LOW;

  always_comb begin
    mix.motors    = motors;
    mix.armed     = armed;
    mix.accepted  = 1'b0;
    mix.roll_int  = roll_int;
    mix.pitch_int = pitch_int;
    unique case (item.req_type)
      tapmm_pkg::REQ_TICK: begin
        mix.roll_int  = ri_new;
        mix.pitch_int = pi_new;
        if (armed && !thr_low) begin
          mix.motors = mixed;
        end else begin
          mix.motors = {4{tapmm_pkg::MOTOR_MIN}};
        end
      end
      tapmm_pkg::REQ_ARM: begin
        if (arm_win) begin
          mix.armed    = 1'b1;
          mix.accepted = 1'b1;
        end
      end
      tapmm_pkg::REQ_DISARM: begin
        if (disarm_win) begin
          mix.armed    = 1'b0;
          mix.accepted = 1'b1;
        end
      end
      default: begin
        // unused request code: nothing changes
      end
    endcase
  end

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the three-axis PID motor mixer core.
`timescale 1ns / 100ps

module testbench;
  import tapmm_pkg::*;

  // Request code the block does not define: no state change, motors repeat.
  localparam logic [1:0] REQ_SPARE = 2'd3;
  // Register indexes that map to nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 60;
  localparam int PHASE_ITEMS    = 140;
  localparam int REPORT_MAX     = 10;

  typedef struct {
    logic [1:0]         kind;
    logic signed [16:0] roll;
    logic signed [16:0] pitch;
    logic signed [16:0] yaw;
    logic signed [16:0] roll_tgt;
    logic signed [16:0] pitch_tgt;
    logic signed [15:0] stick;
    logic [11:0]        thr;
    logic [11:0]        ych;
  } ctl_item_t;

  typedef struct packed {
    logic [3:0][10:0] motor;   // front_a, front_b, rear_a, rear_b
    logic             armed;
    logic             accepted;
  } motor_cmd_t;

  logic clk;
  logic rst = 1'b1;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               req_type = REQ_TICK;
  logic signed [16:0]       roll_angle = '0;
  logic signed [16:0]       pitch_angle = '0;
  logic signed [16:0]       yaw_angle = '0;
  logic signed [16:0]       roll_target = '0;
  logic signed [16:0]       pitch_target = '0;
  logic signed [15:0]       yaw_stick = '0;
  logic [11:0]              throttle_channel = '0;
  logic [11:0]              yaw_channel = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [10:0]              motor_front_a;
  logic [10:0]              motor_front_b;
  logic [10:0]              motor_rear_a;
  logic [10:0]              motor_rear_b;
  logic                     armed_now;
  logic                     request_accepted;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  three_axis_pid_motor_mixer_core i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .req_type         (req_type),
    .roll_angle       (roll_angle),
    .pitch_angle      (pitch_angle),
    .yaw_angle        (yaw_angle),
    .roll_target      (roll_target),
    .pitch_target     (pitch_target),
    .yaw_stick        (yaw_stick),
    .throttle_channel (throttle_channel),
    .yaw_channel      (yaw_channel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .motor_front_a    (motor_front_a),
    .motor_front_b    (motor_front_b),
    .motor_rear_a     (motor_rear_a),
    .motor_rear_b     (motor_rear_b),
    .armed_now        (armed_now),
    .request_accepted (request_accepted),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Controller shadow state: gains, integrators, arm flag, held motors.
  // ---------------------------------------------------------------------
  logic [23:0] g_rp_kp  = RST_ROLL_PITCH_KP;
  logic [23:0] g_yaw_kp = RST_YAW_KP;
  logic [23:0] g_ki     = RST_KI_GAIN;
  logic [23:0] g_kd     = RST_KD_GAIN;
  logic [15:0] g_ilim   = RST_INTEGRAL_LIMIT;
  longint      roll_acc = 0;
  longint      pitch_acc = 0;
  bit          armed_st = 1'b0;
  logic [10:0] motor_hold [4] = '{MOTOR_MIN, MOTOR_MIN, MOTOR_MIN, MOTOR_MIN};

  ctl_item_t   ctl_backlog [$];   // items waiting for the driver
  motor_cmd_t  motor_cmd_q [$];   // predicted results, oldest first
  ctl_item_t   offered;           // item currently on the input port
  int          queued_total = 0;
  int          results_seen = 0;
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          pressure_on = 1'b0;
  bit          pressure_done = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  // gain * value in Q8.16 (or Q.8 for the stick), rounded toward minus infinity
  function automatic longint scaled(input logic [23:0] gain, input longint v, input int sh);
    return (longint'(gain) * v) >>> sh;
  endfunction

  function automatic logic [10:0] sat_motor(input longint s);
    if (s < longint'(MOTOR_MIN) * 256) return MOTOR_MIN;
    if (s >= longint'(MOTOR_MAX) * 256) return MOTOR_MAX;
    return s[18:8];
  endfunction

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // One controller step; updates the shadow state and returns the result.
  function automatic motor_cmd_t pid_mix_step(input ctl_item_t t);
    motor_cmd_t r;
    longint rerr, perr, yerr, stick, sdb, ri, pi, rt, pt, yt, base, lim;
    r.accepted = 1'b0;
    case (t.kind)
      REQ_TICK: begin
        rerr  = longint'(t.roll) - longint'(t.roll_tgt);
        perr  = longint'(t.pitch) - longint'(t.pitch_tgt);
        stick = longint'(t.stick);
        // yaw target uses the raw stick, truncated division
        yerr  = longint'(t.yaw) - 256 * (stick / YAW_DIV);
        lim   = longint'(g_ilim);
        ri = clamp_sym(roll_acc + scaled(g_ki, rerr, 16), lim);
        pi = clamp_sym(pitch_acc + scaled(g_ki, perr, 16), lim);
        if (t.thr < THR_LOW) begin
          ri = 0;
          pi = 0;
        end
        roll_acc  = ri;
        pitch_acc = pi;
        // D term sees the stick after the deadband
        sdb = (stick >= -longint'(YAW_DEADBAND) && stick <= longint'(YAW_DEADBAND)) ?
              0 : stick;
        yt = scaled(g_yaw_kp, yerr, 16) + scaled(g_kd, -sdb, 8);
        rt = scaled(g_rp_kp, rerr, 16) + ri;
        pt = scaled(g_rp_kp, perr, 16) + pi;
        base = longint'(t.thr) * 256;
        if (armed_st && t.thr >= THR_LOW) begin
          motor_hold[0] = sat_motor(base + rt - pt + yt);
          motor_hold[1] = sat_motor(base - rt - pt - yt);
          motor_hold[2] = sat_motor(base - rt + pt + yt);
          motor_hold[3] = sat_motor(base + rt + pt - yt);
        end else begin
          for (int i = 0; i < 4; i++) motor_hold[i] = MOTOR_MIN;
        end
      end
      REQ_ARM: begin
        if (t.thr > WIN_LOW && t.thr < THR_LOW && t.ych > WIN_HIGH && t.ych < WIN_TOP) begin
          armed_st   = 1'b1;
          r.accepted = 1'b1;
        end
      end
      REQ_DISARM: begin
        if (t.thr > WIN_LOW && t.thr < THR_LOW && t.ych > WIN_LOW && t.ych < THR_LOW) begin
          armed_st   = 1'b0;
          r.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < 4; i++) r.motor[i] = motor_hold[i];
    r.armed = armed_st;
    return r;
  endfunction

  function automatic void flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------
  function automatic ctl_item_t mk_item(input logic [1:0] kind, input int roll, input int pitch,
                                        input int yaw, input int roll_tgt, input int pitch_tgt,
                                        input int stick, input int thr, input int ych);
    ctl_item_t t;
    t.kind      = kind;
    t.roll      = roll[16:0];
    t.pitch     = pitch[16:0];
    t.yaw       = yaw[16:0];
    t.roll_tgt  = roll_tgt[16:0];
    t.pitch_tgt = pitch_tgt[16:0];
    t.stick     = stick[15:0];
    t.thr       = thr[11:0];
    t.ych       = ych[11:0];
    return t;
  endfunction

  function automatic int rand_span(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Window-valid arm or disarm most of the time, raw channels otherwise.
  function automatic ctl_item_t window_item(input logic [1:0] kind);
    int thr, ych;
    bit clean;
    clean = ($urandom_range(99) < 80);
    thr = clean ? $urandom_range(1099, 901) : $urandom_range(4095);
    if (!clean) ych = $urandom_range(4095);
    else if (kind == REQ_ARM) ych = $urandom_range(2099, 1901);
    else ych = $urandom_range(1099, 901);
    return mk_item(kind, rand_span(46080), rand_span(46080), rand_span(46080),
                   rand_span(46080), rand_span(46080), $urandom, thr, ych);
  endfunction

  function automatic ctl_item_t rand_item();
    int pick, span, stick, thr;
    pick = $urandom_range(99);
    if (pick < 5) return window_item(REQ_ARM);
    if (pick < 8) return window_item(REQ_DISARM);
    if (pick < 9) return mk_item(REQ_SPARE, rand_span(46080), rand_span(46080),
                                 rand_span(46080), rand_span(46080), rand_span(46080),
                                 $urandom, $urandom, $urandom);
    // control tick: half with small errors so the mix lands mid-range
    span = ($urandom_range(1)) ? 1024 : 46080;
    case ($urandom_range(3))
      0:       stick = rand_span(8);
      1:       stick = rand_span(300);
      default: stick = int'($urandom_range(65535)) - 32768;
    endcase
    pick = $urandom_range(9);
    if (pick < 8) thr = $urandom_range(2000, 1100);
    else if (pick < 9) thr = $urandom_range(1099);
    else thr = $urandom_range(4095);
    return mk_item(REQ_TICK, rand_span(span), rand_span(span), rand_span(span),
                   rand_span(span), rand_span(span), stick, thr, $urandom);
  endfunction

  function automatic void queue_item(input ctl_item_t t);
    ctl_backlog.push_back(t);
    queued_total++;
  endfunction

  // Wait until every item has its result, then let the pipeline drain.
  task automatic settle();
    while (results_seen != queued_total) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Called at a rising edge; leaves cfg_valid high for the caller to drop.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ROLL_PITCH_KP:  g_rp_kp  = data;
      CFG_YAW_KP:         g_yaw_kp = data;
      CFG_KI_GAIN:        g_ki     = data;
      CFG_KD_GAIN:        g_kd     = data;
      CFG_INTEGRAL_LIMIT: g_ilim   = data[15:0];
      default: ;
    endcase
  endtask

  task automatic load_gains(input logic [23:0] rp, input logic [23:0] yk, input logic [23:0] ki,
                            input logic [23:0] kd, input logic [23:0] lim);
    write_reg(CFG_ROLL_PITCH_KP, rp);
    write_reg(CFG_YAW_KP, yk);
    write_reg(CFG_KI_GAIN, ki);
    write_reg(CFG_KD_GAIN, kd);
    write_reg(CFG_INTEGRAL_LIMIT, lim);
    // unmapped index must leave everything alone
    write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)), 24'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Each phase opens with a clean arm so the ticks drive the motors.
  task automatic run_phase(input int n);
    queue_item(mk_item(REQ_ARM, 0, 0, 0, 0, 0, 0, 1000, 2000));
    repeat (n) queue_item(rand_item());
    settle();
  endtask

  // ---------------------------------------------------------------------
  // Driver: offers backlog items, predicts on acceptance.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) motor_cmd_q.push_back(pid_mix_step(offered));
      // a stalled item stays put; otherwise maybe present the next one
      if (!in_valid || !in_stall) begin
        if (ctl_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = ctl_backlog.pop_front();
          req_type         <= offered.kind;
          roll_angle       <= offered.roll;
          pitch_angle      <= offered.pitch;
          yaw_angle        <= offered.yaw;
          roll_target      <= offered.roll_tgt;
          pitch_target     <= offered.pitch_tgt;
          yaw_stick        <= offered.stick;
          throttle_channel <= offered.thr;
          yaw_channel      <= offered.ych;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks results, drives out_stall (random or long hold-off).
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    motor_cmd_t got, want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.motor[0] = motor_front_a;
        got.motor[1] = motor_front_b;
        got.motor[2] = motor_rear_a;
        got.motor[3] = motor_rear_b;
        got.armed    = armed_now;
        got.accepted = request_accepted;
        if (motor_cmd_q.size() == 0) begin
          flag_error("result with no item outstanding");
        end else begin
          want = motor_cmd_q.pop_front();
          for (int m = 0; m < 4; m++)
            if (got.motor[m] !== want.motor[m])
              flag_error($sformatf("result %0d motor %0d: expected %0d, got %0d",
                                   results_seen, m, want.motor[m], got.motor[m]));
          if (got.armed !== want.armed)
            flag_error($sformatf("result %0d armed_now: expected %0b, got %0b",
                                 results_seen, want.armed, got.armed));
          if (got.accepted !== want.accepted)
            flag_error($sformatf("result %0d request_accepted: expected %0b, got %0b",
                                 results_seen, want.accepted, got.accepted));
          results_seen++;
        end
      end
      // long hold-off so the block backs up into its input
      if (pressure_on && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run if no channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("three_axis_pid_motor_mixer_core test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed, on reset gains: arm windows, saturation, deadband, low throttle.
    send_idle_pct = 14;
    recv_idle_pct = 57;
    queue_item(mk_item(REQ_TICK, 1000, -500, 0, 0, 0, 0, 1500, 1500));     // disarmed
    queue_item(mk_item(REQ_ARM, 0, 0, 0, 0, 0, 0, 900, 2000));             // throttle edge
    queue_item(mk_item(REQ_ARM, 0, 0, 0, 0, 0, 0, 1100, 2000));
    queue_item(mk_item(REQ_ARM, 0, 0, 0, 0, 0, 0, 1000, 1900));            // yaw edge
    queue_item(mk_item(REQ_ARM, 0, 0, 0, 0, 0, 0, 1000, 2100));
    queue_item(mk_item(REQ_ARM, 0, 0, 0, 0, 0, 0, 901, 2099));             // just inside
    queue_item(mk_item(REQ_TICK, 46080, -46080, 46080, -46080, 46080, -32768, 1500, 0));
    queue_item(mk_item(REQ_TICK, -46080, 46080, -46080, 46080, -46080, 32767, 1500, 4095));
    queue_item(mk_item(REQ_DISARM, 0, 0, 0, 0, 0, 0, 1099, 1100));
    queue_item(mk_item(REQ_DISARM, 0, 0, 0, 0, 0, 0, 1000, 900));
    queue_item(mk_item(REQ_SPARE, 300, 300, 300, 0, 0, 100, 1000, 1000));
    queue_item(mk_item(REQ_TICK, 200, -100, 50, 0, 0, 32767, 4095, 2000));
    queue_item(mk_item(REQ_TICK, 500, 500, 0, 0, 0, 5, 1099, 2000));       // integrators clear
    queue_item(mk_item(REQ_TICK, 200, 0, 0, 0, 0, -5, 1100, 2000));
    queue_item(mk_item(REQ_TICK, 0, 300, 100, 0, 0, 6, 1300, 2000));
    queue_item(mk_item(REQ_TICK, -300, 0, -46080, 0, 0, -6, 1300, 2000));
    queue_item(mk_item(REQ_DISARM, 0, 0, 0, 0, 0, 0, 1099, 1099));         // motors held
    queue_item(mk_item(REQ_TICK, 100, 100, 100, 0, 0, 0, 1500, 2000));     // disarmed
    queue_item(mk_item(REQ_TICK, 100, 100, 100, 0, 0, -32768, 0, 2000));
    queue_item(mk_item(REQ_ARM, 0, 0, 0, 0, 0, 0, 0, 4095));
    queue_item(mk_item(REQ_DISARM, 0, 0, 0, 0, 0, 0, 4095, 0));
    settle();

    // Random phases, sender light / receiver heavy idling.
    load_gains(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
    run_phase(PHASE_ITEMS);
    load_gains(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    run_phase(PHASE_ITEMS);

    // Roles swapped.
    send_idle_pct = 57;
    recv_idle_pct = 14;
    load_gains('0, '0, '0, '0, '0);
    run_phase(PHASE_ITEMS);
    load_gains(24'($urandom_range(24'h080000)), 24'($urandom_range(24'h080000)),
               24'($urandom_range(24'h001000)), 24'($urandom_range(24'h040000)),
               24'($urandom_range(24'h001000)));
    run_phase(PHASE_ITEMS);

    // No idling; first phase carries the long receiver hold-off.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_gains(RST_ROLL_PITCH_KP, RST_YAW_KP, RST_KI_GAIN, RST_KD_GAIN,
               24'(RST_INTEGRAL_LIMIT));
    pressure_on = 1'b1;
    run_phase(PHASE_ITEMS);
    load_gains(24'($urandom), 24'($urandom), 24'hFFFFFF, 24'($urandom),
               24'($urandom_range(65535)));
    run_phase(PHASE_ITEMS);

    if (mismatch_count == 0 && motor_cmd_q.size() == 0) begin
      $display("three_axis_pid_motor_mixer_core test passed");
    end else begin
      $display("three_axis_pid_motor_mixer_core test failed");
    end
    $finish;
  end

endmodule

@@ three_axis_pid_motor_mixer_core.f @@
+incdir+rtl
rtl/tapmm_pkg.sv
rtl/tapmm_in_stage.sv
rtl/tapmm_mixer.sv
rtl/three_axis_pid_motor_mixer_core.sv
test/testbench.sv
